### rtl/core/cci_pkg.sv
// Shared types, constants and arithmetic helpers for the circle intersection unit.
package cci_pkg;

  localparam int SQRT_STEPS = 64;
  localparam int DIV_STEPS  = 41;
  localparam int PIPE_DEPTH = 8 + SQRT_STEPS + 5 + DIV_STEPS + 1;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 2;

  localparam logic [DIV_STEPS-1:0] OFFSET_CLIP = {1'b1, {(DIV_STEPS-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_FAR    = 2'd1,
    ST_INSIDE = 2'd2,
    ST_SAME   = 2'd3
  } cci_status_t;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic [30:0]        r1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic [30:0]        r2;
  } cci_in_t;

  typedef struct packed {
    cci_status_t        status;
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
  } cci_res_t;

  typedef struct packed {
    cci_status_t        status;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic [63:0]        d2;
    logic [63:0]        kmag;
    logic               nk;
    logic               ndx;
    logic               ndy;
    logic [31:0]        adx;
    logic [31:0]        ady;
  } cci_geo_t;

  typedef struct packed {
    logic [127:0] rad;
    logic [65:0]  rem;
    logic [63:0]  root;
    cci_geo_t     geo;
  } cci_sq_t;

  typedef struct packed {
    cci_status_t                  status;
    logic signed [31:0]           x1;
    logic signed [31:0]           y1;
    logic [64:0]                  den;
    logic [3:0]                   neg;
    logic [3:0]                   ovf;
    logic [3:0][97:0]             rem;
    logic [3:0][DIV_STEPS-1:0]    quo;
  } cci_dv_t;

  typedef struct packed {
    logic        neg;
    logic [96:0] mag;
  } cci_sm_t;

  typedef logic [3:0][63:0] cci_pp_t;
  typedef logic [1:0][63:0] cci_pp2_t;

  // Four 32x32 partial products of a 64x64 multiplication.
  function automatic cci_pp_t cci_mul_pp(input logic [63:0] a, input logic [63:0] b);
    cci_pp_t p;
    p[0] = 64'(a[31:0])  * 64'(b[31:0]);
    p[1] = 64'(a[31:0])  * 64'(b[63:32]);
    p[2] = 64'(a[63:32]) * 64'(b[31:0]);
    p[3] = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  function automatic logic [127:0] cci_pp_sum(input cci_pp_t p);
    return {64'd0, p[0]} + {32'd0, p[1], 32'd0} + {32'd0, p[2], 32'd0} + {p[3], 64'd0};
  endfunction

  // Two 32x32 partial products of a 64x32 multiplication.
  function automatic cci_pp2_t cci_mul_pp2(input logic [63:0] a, input logic [31:0] b);
    cci_pp2_t p;
    p[0] = 64'(a[31:0])  * 64'(b);
    p[1] = 64'(a[63:32]) * 64'(b);
    return p;
  endfunction

  function automatic logic [95:0] cci_pp2_sum(input cci_pp2_t p);
    return {32'd0, p[0]} + {p[1], 32'd0};
  endfunction

  // Signed-magnitude addition of two products.
  function automatic cci_sm_t cci_smsum(input logic sa, input logic [95:0] ma,
                                        input logic sb, input logic [95:0] mb);
    cci_sm_t r;
    if (sa == sb) begin
      r.neg = sa;
      r.mag = {1'b0, ma} + {1'b0, mb};
    end else if (ma >= mb) begin
      r.neg = sa;
      r.mag = {1'b0, ma - mb};
    end else begin
      r.neg = sb;
      r.mag = {1'b0, mb - ma};
    end
    return r;
  endfunction

  // One result bit of the digit-by-digit square root.
  function automatic cci_sq_t cci_sqrt_step(input cci_sq_t s);
    cci_sq_t     r;
    logic [67:0] rem_sh;
    logic [67:0] trial;
    r      = s;
    rem_sh = {s.rem, s.rad[127:126]};
    trial  = {2'b00, s.root, 2'b01};
    if (rem_sh >= trial) begin
      r.rem  = 66'(rem_sh - trial);
      r.root = {s.root[62:0], 1'b1};
    end else begin
      r.rem  = rem_sh[65:0];
      r.root = {s.root[62:0], 1'b0};
    end
    r.rad = {s.rad[125:0], 2'b00};
    return r;
  endfunction

  // Clip the rounded offset, move from the center and saturate to 32 bits.
  function automatic logic [31:0] cci_place(input logic signed [31:0] center, input logic neg,
                                            input logic [DIV_STEPS-1:0] quo, input logic ovf);
    logic [DIV_STEPS-1:0] qc;
    logic [41:0]          c;
    logic [41:0]          v;
    qc = (ovf || quo > OFFSET_CLIP) ? OFFSET_CLIP : quo;
    c  = {{10{center[31]}}, center};
    v  = neg ? c - {1'b0, qc} : c + {1'b0, qc};
    if (v[41:31] == {11{v[41]}}) begin
      return v[31:0];
    end else if (v[41]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

endpackage

### rtl/core/cci_datapath.sv
// Pipelined geometry datapath: distances, square root, division and point placement.
module cci_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ce,
  input  logic              in_valid,
  input  cci_pkg::cci_in_t  in_item,
  output logic              out_valid,
  output cci_pkg::cci_res_t out_item
);

  localparam int SQ = cci_pkg::SQRT_STEPS;
  localparam int DV = cci_pkg::DIV_STEPS;
  localparam int PD = cci_pkg::PIPE_DEPTH;

  logic [PD-1:0] v_r;

  // Stage 1: center differences, radius sum and difference.
  logic signed [31:0] s1_x1_r, s1_y1_r;
  logic [32:0]        s1_dx_r, s1_dy_r;
  logic [31:0]        s1_sum_r;
  logic [30:0]        s1_diff_r, s1_r1_r;
  logic               s1_r1ge_r;
  // Stage 2: magnitudes.
  logic signed [31:0] s2_x1_r, s2_y1_r;
  logic [31:0]        s2_adx_r, s2_ady_r, s2_sum_r;
  logic               s2_ndx_r, s2_ndy_r, s2_r1ge_r;
  logic [30:0]        s2_diff_r, s2_r1_r;
  // Stage 3: squares and products.
  logic signed [31:0] s3_x1_r, s3_y1_r;
  logic [31:0]        s3_adx_r, s3_ady_r;
  logic               s3_ndx_r, s3_ndy_r, s3_r1ge_r;
  logic [63:0]        s3_adx2_r, s3_ady2_r, s3_sum2_r;
  logic [61:0]        s3_diff2_r, s3_r1sq_r;
  logic [62:0]        s3_ds_r;
  // Stage 4: squared distance.
  logic signed [31:0] s4_x1_r, s4_y1_r;
  logic [31:0]        s4_adx_r, s4_ady_r;
  logic               s4_ndx_r, s4_ndy_r, s4_r1ge_r;
  logic [64:0]        s4_d2_r;
  logic [63:0]        s4_sum2_r;
  logic [61:0]        s4_diff2_r, s4_r1sq_r;
  logic [62:0]        s4_ds_r;
  // Stages 5 to 7: classification, K and the radicand products.
  cci_pkg::cci_geo_t  s5_geo_r, s6_geo_r, s7_geo_r;
  logic [63:0]        s5_r4_r;
  cci_pkg::cci_pp_t   s6_ppa_r, s6_ppb_r;
  logic [127:0]       s7_pa_r, s7_pb_r;
  cci_pkg::cci_geo_t  s5_geo_nxt;

  cci_pkg::cci_sq_t   sq_r [0:SQ];

  // Stages A to D after the square root.
  cci_pkg::cci_geo_t  sa_geo_r, sb_geo_r, sc_geo_r;
  cci_pkg::cci_pp2_t  sa_kx_r, sa_ky_r, sa_ty_r, sa_tx_r;
  logic [95:0]        sb_kx_r, sb_ky_r, sb_ty_r, sb_tx_r;
  cci_pkg::cci_sm_t   sc_sm_r [4];
  cci_pkg::cci_dv_t   sd_r;
  cci_pkg::cci_dv_t   dv0_nxt;
  cci_pkg::cci_dv_t   dv_r [0:DV];
  cci_pkg::cci_res_t  sf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[PD-2:0], in_valid};
    end
  end

  always_comb begin
    s5_geo_nxt.x1  = s4_x1_r;
    s5_geo_nxt.y1  = s4_y1_r;
    s5_geo_nxt.d2  = s4_d2_r[63:0];
    s5_geo_nxt.ndx = s4_ndx_r;
    s5_geo_nxt.ndy = s4_ndy_r;
    s5_geo_nxt.adx = s4_adx_r;
    s5_geo_nxt.ady = s4_ady_r;
    priority if (s4_d2_r[64]) begin
      s5_geo_nxt.status = cci_pkg::ST_FAR;
    end else if (s4_d2_r == '0) begin
      s5_geo_nxt.status = cci_pkg::ST_SAME;
    end else if (s4_d2_r[63:0] > s4_sum2_r) begin
      s5_geo_nxt.status = cci_pkg::ST_FAR;
    end else if (s4_d2_r[63:0] < {2'b00, s4_diff2_r}) begin
      s5_geo_nxt.status = cci_pkg::ST_INSIDE;
    end else begin
      s5_geo_nxt.status = cci_pkg::ST_HIT;
    end
    priority if (s4_r1ge_r) begin
      s5_geo_nxt.kmag = s4_d2_r[63:0] + {1'b0, s4_ds_r};
      s5_geo_nxt.nk   = 1'b0;
    end else if (s4_d2_r[63:0] >= {1'b0, s4_ds_r}) begin
      s5_geo_nxt.kmag = s4_d2_r[63:0] - {1'b0, s4_ds_r};
      s5_geo_nxt.nk   = 1'b0;
    end else begin
      s5_geo_nxt.kmag = {1'b0, s4_ds_r} - s4_d2_r[63:0];
      s5_geo_nxt.nk   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_x1_r   <= in_item.x1;
      s1_y1_r   <= in_item.y1;
      s1_dx_r   <= {in_item.x2[31], in_item.x2} - {in_item.x1[31], in_item.x1};
      s1_dy_r   <= {in_item.y2[31], in_item.y2} - {in_item.y1[31], in_item.y1};
      s1_sum_r  <= {1'b0, in_item.r1} + {1'b0, in_item.r2};
      s1_r1ge_r <= in_item.r1 >= in_item.r2;
      s1_diff_r <= (in_item.r1 >= in_item.r2) ? in_item.r1 - in_item.r2
                                              : in_item.r2 - in_item.r1;
      s1_r1_r   <= in_item.r1;

      s2_x1_r   <= s1_x1_r;
      s2_y1_r   <= s1_y1_r;
      s2_ndx_r  <= s1_dx_r[32];
      s2_ndy_r  <= s1_dy_r[32];
      s2_adx_r  <= s1_dx_r[32] ? 32'(-s1_dx_r) : s1_dx_r[31:0];
      s2_ady_r  <= s1_dy_r[32] ? 32'(-s1_dy_r) : s1_dy_r[31:0];
      s2_sum_r  <= s1_sum_r;
      s2_diff_r <= s1_diff_r;
      s2_r1ge_r <= s1_r1ge_r;
      s2_r1_r   <= s1_r1_r;

      s3_x1_r    <= s2_x1_r;
      s3_y1_r    <= s2_y1_r;
      s3_adx_r   <= s2_adx_r;
      s3_ady_r   <= s2_ady_r;
      s3_ndx_r   <= s2_ndx_r;
      s3_ndy_r   <= s2_ndy_r;
      s3_r1ge_r  <= s2_r1ge_r;
      s3_adx2_r  <= 64'(s2_adx_r) * 64'(s2_adx_r);
      s3_ady2_r  <= 64'(s2_ady_r) * 64'(s2_ady_r);
      s3_sum2_r  <= 64'(s2_sum_r) * 64'(s2_sum_r);
      s3_diff2_r <= 62'(s2_diff_r) * 62'(s2_diff_r);
      s3_ds_r    <= 63'(s2_diff_r) * 63'(s2_sum_r);
      s3_r1sq_r  <= 62'(s2_r1_r) * 62'(s2_r1_r);

      s4_x1_r    <= s3_x1_r;
      s4_y1_r    <= s3_y1_r;
      s4_adx_r   <= s3_adx_r;
      s4_ady_r   <= s3_ady_r;
      s4_ndx_r   <= s3_ndx_r;
      s4_ndy_r   <= s3_ndy_r;
      s4_r1ge_r  <= s3_r1ge_r;
      s4_d2_r    <= {1'b0, s3_adx2_r} + {1'b0, s3_ady2_r};
      s4_sum2_r  <= s3_sum2_r;
      s4_diff2_r <= s3_diff2_r;
      s4_ds_r    <= s3_ds_r;
      s4_r1sq_r  <= s3_r1sq_r;

      s5_geo_r <= s5_geo_nxt;
      s5_r4_r  <= {s4_r1sq_r, 2'b00};

      s6_geo_r <= s5_geo_r;
      s6_ppa_r <= cci_pkg::cci_mul_pp(s5_r4_r, s5_geo_r.d2);
      s6_ppb_r <= cci_pkg::cci_mul_pp(s5_geo_r.kmag, s5_geo_r.kmag);

      s7_geo_r <= s6_geo_r;
      s7_pa_r  <= cci_pkg::cci_pp_sum(s6_ppa_r);
      s7_pb_r  <= cci_pkg::cci_pp_sum(s6_ppb_r);

      sq_r[0].rad  <= s7_pa_r - s7_pb_r;
      sq_r[0].rem  <= '0;
      sq_r[0].root <= '0;
      sq_r[0].geo  <= s7_geo_r;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (ce) begin
        sq_r[k+1] <= cci_pkg::cci_sqrt_step(sq_r[k]);
      end
    end
  end

  // A quotient too large for the divider is flagged and later clipped.
  always_comb begin
    dv0_nxt = sd_r;
    for (int j = 0; j < 4; j++) begin
      dv0_nxt.ovf[j] = {8'd0, sd_r.rem[j]} >= {sd_r.den, {DV{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sa_geo_r <= sq_r[SQ].geo;
      sa_kx_r  <= cci_pkg::cci_mul_pp2(sq_r[SQ].geo.kmag, sq_r[SQ].geo.adx);
      sa_ky_r  <= cci_pkg::cci_mul_pp2(sq_r[SQ].geo.kmag, sq_r[SQ].geo.ady);
      sa_ty_r  <= cci_pkg::cci_mul_pp2(sq_r[SQ].root, sq_r[SQ].geo.ady);
      sa_tx_r  <= cci_pkg::cci_mul_pp2(sq_r[SQ].root, sq_r[SQ].geo.adx);

      sb_geo_r <= sa_geo_r;
      sb_kx_r  <= cci_pkg::cci_pp2_sum(sa_kx_r);
      sb_ky_r  <= cci_pkg::cci_pp2_sum(sa_ky_r);
      sb_ty_r  <= cci_pkg::cci_pp2_sum(sa_ty_r);
      sb_tx_r  <= cci_pkg::cci_pp2_sum(sa_tx_r);

      sc_geo_r   <= sb_geo_r;
      sc_sm_r[0] <= cci_pkg::cci_smsum(sb_geo_r.nk ^ sb_geo_r.ndx, sb_kx_r,
                                       !sb_geo_r.ndy, sb_ty_r);
      sc_sm_r[1] <= cci_pkg::cci_smsum(sb_geo_r.nk ^ sb_geo_r.ndy, sb_ky_r,
                                       sb_geo_r.ndx, sb_tx_r);
      sc_sm_r[2] <= cci_pkg::cci_smsum(sb_geo_r.nk ^ sb_geo_r.ndx, sb_kx_r,
                                       sb_geo_r.ndy, sb_ty_r);
      sc_sm_r[3] <= cci_pkg::cci_smsum(sb_geo_r.nk ^ sb_geo_r.ndy, sb_ky_r,
                                       !sb_geo_r.ndx, sb_tx_r);

      sd_r.status <= sc_geo_r.status;
      sd_r.x1     <= sc_geo_r.x1;
      sd_r.y1     <= sc_geo_r.y1;
      sd_r.den    <= {sc_geo_r.d2, 1'b0};
      sd_r.ovf    <= '0;
      sd_r.quo    <= '0;
      for (int j = 0; j < 4; j++) begin
        sd_r.neg[j] <= sc_sm_r[j].neg;
        // Adding d2 before the divide by 2*d2 rounds halves away from zero.
        sd_r.rem[j] <= {1'b0, sc_sm_r[j].mag} + {34'd0, sc_geo_r.d2};
      end

      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar k = 0; k < DV; k++) begin : g_div
    localparam int SH = DV - 1 - k;
    cci_pkg::cci_dv_t dv_nxt;
    logic [105:0]     dsh;
    always_comb begin
      dv_nxt = dv_r[k];
      dsh    = {41'd0, dv_r[k].den} << SH;
      for (int j = 0; j < 4; j++) begin
        if ({8'd0, dv_r[k].rem[j]} >= dsh) begin
          dv_nxt.rem[j]     = dv_r[k].rem[j] - dsh[97:0];
          dv_nxt.quo[j][SH] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        dv_r[k+1] <= dv_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sf_r.status <= dv_r[DV].status;
      if (dv_r[DV].status == cci_pkg::ST_HIT) begin
        sf_r.p1x <= cci_pkg::cci_place(dv_r[DV].x1, dv_r[DV].neg[0], dv_r[DV].quo[0],
                                       dv_r[DV].ovf[0]);
        sf_r.p1y <= cci_pkg::cci_place(dv_r[DV].y1, dv_r[DV].neg[1], dv_r[DV].quo[1],
                                       dv_r[DV].ovf[1]);
        sf_r.p2x <= cci_pkg::cci_place(dv_r[DV].x1, dv_r[DV].neg[2], dv_r[DV].quo[2],
                                       dv_r[DV].ovf[2]);
        sf_r.p2y <= cci_pkg::cci_place(dv_r[DV].y1, dv_r[DV].neg[3], dv_r[DV].quo[3],
                                       dv_r[DV].ovf[3]);
      end else begin
        sf_r.p1x <= '0;
        sf_r.p1y <= '0;
        sf_r.p2x <= '0;
        sf_r.p2y <= '0;
      end
    end
  end

  assign out_valid = v_r[PD-1];
  assign out_item  = sf_r;

endmodule

### rtl/core/circle_circle_intersection_unit.sv
// Top level of the circle-circle intersection unit: stream ports and output register.
//
// Each transfer on the input stream carries two circles in signed Q16.16; each
// transfer on the output stream carries a status code and the two crossing points.
// The unit accepts one item in every clock cycle unless the pipeline holds, and
// delivers results in order; on its way to the output register a result passes
// the 64-stage square root of the half-chord term and the 41-stage divider that
// forms the rounded point offsets. The whole pipeline advances together; it holds
// only when a result waits in the output register and the last stage is also
// full, so idle slots are squeezed out while the output side stalls.
// Status 0 means the circles cross or touch (touching gives two equal points),
// 1 means they are too far apart, 2 means one lies inside the other, and 3 means
// the centers coincide; for any status other than 0 all point fields are zero.
// Point coordinates saturate to the signed 32-bit range.
module circle_circle_intersection_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: first_center_x, first_center_y, first_radius,
  // second_center_x, second_center_y, second_radius, two zero pad bits.
  input  logic [cci_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: first_point_x, first_point_y, second_point_x, second_point_y.
  output logic [cci_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Fields from bit 0 up: status.
  output logic [cci_pkg::OUT_USER_W-1:0]      out_tuser
);

  cci_pkg::cci_in_t  in_item;
  cci_pkg::cci_res_t dp_item;
  logic              dp_valid;
  logic              ce;
  logic              out_load;
  logic              out_valid_r;
  cci_pkg::cci_res_t out_item_r;

  assign in_item.x1 = in_tdata[31:0];
  assign in_item.y1 = in_tdata[63:32];
  assign in_item.r1 = in_tdata[94:64];
  assign in_item.x2 = in_tdata[126:95];
  assign in_item.y2 = in_tdata[158:127];
  assign in_item.r2 = in_tdata[189:159];

  // The output register takes a new result whenever it is empty or being drained.
  assign out_load  = out_tready || !out_valid_r;
  // The pipeline may move unless its last stage holds a result that cannot leave.
  assign ce        = out_load || !dp_valid;
  assign in_tready = ce;

  cci_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_tvalid),
    .in_item   (in_item),
    .out_valid (dp_valid),
    .out_item  (dp_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= dp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= dp_item;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_item_r.p2y, out_item_r.p2x, out_item_r.p1y, out_item_r.p1x};
  assign out_tuser  = out_item_r.status;

endmodule

### rtl/core/cci_checker.sv
// Port-level checks for the circle-circle intersection unit and their binding.
module cci_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [cci_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [cci_pkg::OUT_USER_W-1:0] out_tuser
);

  // A result that waits must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  // Points carry no meaning unless the circles cross, and are then zero.
  a_zero_pts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != cci_pkg::ST_HIT |-> out_tdata == '0)
    else $error("nonzero points with a non-crossing status");

  // With the output register empty the pipeline never holds back input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input held back while the output is empty");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind circle_circle_intersection_unit cci_checker u_cci_checker (.*);
